/* design/fixed_block_pool_allocator_unit_macros.svh */
// assertion macros shared by the checker of the block pool allocator
// depends on nothing; included by files that assert
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FBPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fbpa assertion failed");

// next-cycle implication, disabled while reset is low
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fbpa assertion failed");

`endif

/* design/fbpa_pkg.sv */
// shared types and constants of the fixed block pool allocator
// depends on nothing
package fbpa_pkg;

    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int SIZE_W  = 32;
    localparam int IDX_SPAN = 256;

    localparam logic [CNT_W-1:0] COUNT_MAX   = 9'd511;
    localparam logic [CNT_W-1:0] POOL_RESET  = 9'd256;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_stall;
    } dp_sts_t;

endpackage

/* design/fixed_block_pool_allocator_unit.sv */
// Fixed-size block pool allocator. Each input word is an allocate (opcode 0) or a free
// (opcode 1); each yields exactly one result word with a status and, for a good allocate,
// the granted block. Allocate hands out the most recently freed block, else the lowest
// never-used one. A request is handled in two steps: the accept cycle reads the link memory at
// the free-list head; the execute state then updates the list and loads the result register,
// waiting there while that register still holds a word not yet taken. Writing the pool size
// (cfg channel, always ready) restarts the pool; do so only while idle. Reset needs no
// clearing pass: the pool size comes up at 256 and the free list empty.
// depends on fbpa_pkg, fbpa_ctrl, fbpa_datapath
module fixed_block_pool_allocator_unit #(
    parameter int MAX_BLOCKS  = 256,
    parameter int BLOCK_BYTES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [fbpa_pkg::SIZE_W-1:0]   s_request_size,
    input  logic [fbpa_pkg::IDX_W-1:0]    s_block_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [fbpa_pkg::IDX_W-1:0]    m_granted_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fbpa_pkg::CNT_W-1:0]    cfg_pool_blocks
);

    fbpa_pkg::dp_cmd_t cmd;
    fbpa_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    fbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fbpa_datapath #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_opcode        (s_opcode),
        .s_request_size  (s_request_size),
        .s_block_index   (s_block_index),
        .cfg_valid       (cfg_valid),
        .cfg_pool_blocks (cfg_pool_blocks),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_index (m_granted_index)
    );

endmodule

/* design/fbpa_ctrl.sv */
// controller of the block pool allocator: accept / execute sequencing
// depends on fbpa_pkg
module fbpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fbpa_pkg::dp_sts_t  sts,
    output fbpa_pkg::dp_cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    always_comb begin
        cmd.load   = s_valid & s_ready_reg;
        cmd.commit = (state_reg == S_EXEC) & ~sts.out_stall;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait here while the result register still holds an untaken word
                if (cmd.commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

/* design/fbpa_datapath.sv */
// datapath of the block pool allocator: link memory, list head, counters,
// pool size register and result register; depends on fbpa_pkg
module fbpa_datapath #(
    parameter int MAX_BLOCKS  = 256,
    parameter int BLOCK_BYTES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fbpa_pkg::dp_cmd_t             cmd,
    output fbpa_pkg::dp_sts_t             sts,
    input  logic                          s_opcode,
    input  logic [fbpa_pkg::SIZE_W-1:0]   s_request_size,
    input  logic [fbpa_pkg::IDX_W-1:0]    s_block_index,
    input  logic                          cfg_valid,
    input  logic [fbpa_pkg::CNT_W-1:0]    cfg_pool_blocks,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [fbpa_pkg::IDX_W-1:0]    m_granted_index
);

    localparam int DEPTH = (MAX_BLOCKS < fbpa_pkg::IDX_SPAN) ? MAX_BLOCKS : fbpa_pkg::IDX_SPAN;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [fbpa_pkg::CNT_W-1:0]  DEPTH_CNT   = fbpa_pkg::CNT_W'(DEPTH);
    localparam logic [fbpa_pkg::SIZE_W-1:0] BLOCK_LIMIT = fbpa_pkg::SIZE_W'(BLOCK_BYTES);

    logic [fbpa_pkg::IDX_W-1:0] link_mem [DEPTH];

    logic                       op_reg;
    logic                       big_reg;
    logic [fbpa_pkg::IDX_W-1:0] idx_reg;
    logic [fbpa_pkg::IDX_W-1:0] link_rd_reg;

    logic [fbpa_pkg::IDX_W-1:0] free_head_reg, free_head_next;
    logic [fbpa_pkg::CNT_W-1:0] freed_count_reg, freed_count_next;
    logic [fbpa_pkg::CNT_W-1:0] fresh_next_reg, fresh_next_next;
    logic [fbpa_pkg::CNT_W-1:0] pool_blocks_reg;

    logic                       m_valid_reg;
    fbpa_pkg::status_t          m_status_reg, status_next;
    logic [fbpa_pkg::IDX_W-1:0] m_granted_reg, granted_next;

    logic [fbpa_pkg::CNT_W-1:0] pool_n;
    logic                       link_we;

    assign pool_n = (pool_blocks_reg > DEPTH_CNT) ? DEPTH_CNT : pool_blocks_reg;

    always_comb begin
        free_head_next   = free_head_reg;
        freed_count_next = freed_count_reg;
        fresh_next_next  = fresh_next_reg;
        status_next      = fbpa_pkg::ST_OK;
        granted_next     = '0;
        link_we          = 1'b0;
        if (op_reg == fbpa_pkg::OP_ALLOC) begin
            if (big_reg) begin
                status_next = fbpa_pkg::ST_TOO_LARGE;
            end else if (freed_count_reg != '0) begin
                // pop: link of the head was read when the word was accepted
                granted_next     = free_head_reg;
                free_head_next   = link_rd_reg;
                freed_count_next = freed_count_reg - 1'b1;
            end else if (fresh_next_reg < pool_n) begin
                granted_next    = fresh_next_reg[fbpa_pkg::IDX_W-1:0];
                fresh_next_next = fresh_next_reg + 1'b1;
            end else begin
                status_next = fbpa_pkg::ST_EMPTY;
            end
        end else begin
            if ({1'b0, idx_reg} >= pool_n) begin
                status_next = fbpa_pkg::ST_BAD_INDEX;
            end else begin
                link_we        = 1'b1;
                free_head_next = idx_reg;
                if (freed_count_reg < fbpa_pkg::COUNT_MAX) begin
                    freed_count_next = freed_count_reg + 1'b1;
                end
            end
        end
    end

    // link memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.commit && link_we) begin
            link_mem[idx_reg[AW-1:0]] <= free_head_reg;
        end
        if (cmd.load) begin
            link_rd_reg <= link_mem[free_head_reg[AW-1:0]];
        end
    end

    // captured request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_opcode;
            big_reg <= (s_request_size > BLOCK_LIMIT);
            idx_reg <= s_block_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_blocks_reg <= fbpa_pkg::POOL_RESET;
            free_head_reg   <= '0;
            freed_count_reg <= '0;
            fresh_next_reg  <= '0;
        end else if (cfg_valid) begin
            // new pool size restarts the pool
            pool_blocks_reg <= cfg_pool_blocks;
            free_head_reg   <= '0;
            freed_count_reg <= '0;
            fresh_next_reg  <= '0;
        end else if (cmd.commit) begin
            free_head_reg   <= free_head_next;
            freed_count_reg <= freed_count_next;
            fresh_next_reg  <= fresh_next_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status_reg  <= status_next;
            m_granted_reg <= granted_next;
        end
    end

    assign sts.out_stall   = m_valid_reg & ~m_ready;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_index = m_granted_reg;

endmodule

/* design/fbpa_checker.sv */
// port-level checker of the block pool allocator, bound to the top level
// depends on fbpa_pkg and fixed_block_pool_allocator_unit_macros.svh
`include "fixed_block_pool_allocator_unit_macros.svh"

module fbpa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [1:0]                    m_status,
    input logic [fbpa_pkg::IDX_W-1:0]    m_granted_index
);

    logic out_hold;
    logic failed_word;
    logic in_accept;

    assign out_hold    = m_valid & ~m_ready;
    assign failed_word = m_valid & (m_status != fbpa_pkg::ST_OK);
    assign in_accept   = s_valid & s_ready;

    // result word holds while stalled
    `FBPA_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_hold, m_valid && $stable(m_status) && $stable(m_granted_index))

    // a failed result word (any status but ok) shows block zero
    `FBPA_ASSERT_IMPLY(a_fail_zero, aclk, aresetn, failed_word, m_granted_index == '0)

    // one request in flight: no accept in the cycle after an accept
    `FBPA_ASSERT_NEXT(a_one_inflight, aclk, aresetn, in_accept, !s_ready)

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (.*);
